FILE: rtl/core/bemf_pkg.sv
// Shared types and constants for the back-EMF integration commutation detector.
// No dependencies; used by the interfaces, the update logic, the top level and the checker.
package bemf_pkg;

    localparam logic [15:0] U16_MAX        = 16'hFFFF;
    localparam logic [2:0]  NUM_STEPS      = 3'd6;

    localparam logic        REQ_TICK       = 1'b0;
    localparam logic        REQ_SAMPLE     = 1'b1;

    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_THRESHOLD = 3'd0;
    localparam cfg_idx_t CFG_BLANKING  = 3'd1;
    localparam cfg_idx_t CFG_DIRECTION = 3'd2;
    localparam cfg_idx_t CFG_SLOPE     = 3'd3;

    localparam logic [15:0] RST_THRESHOLD  = 16'd1000;
    localparam logic [7:0]  RST_BLANKING   = 8'd2;
    localparam logic        RST_DIRECTION  = 1'b0;
    localparam logic [5:0]  RST_SLOPE      = 6'd21;
    localparam logic [7:0]  RST_BLANK_LEFT = 8'd2;

    typedef struct packed {
        logic       req_type;
        logic [9:0] sample;
        logic       sample_is_supply;
        logic [2:0] comm_step;
    } item_t;

    typedef struct packed {
        logic        commutate;
        logic [15:0] period;
        logic [15:0] integral_level;
    } result_t;

    typedef struct packed {
        cfg_idx_t    index;
        logic [15:0] data;
    } cfg_beat_t;

    typedef struct packed {
        logic [15:0] threshold;
        logic [7:0]  blanking;
        logic        direction;
        logic [5:0]  slope;
    } cfg_t;

    typedef struct packed {
        logic [15:0] tick_count;
        logic [15:0] period;
        logic [15:0] integral;
        logic [9:0]  supply;
        logic [7:0]  blank_left;
        logic [2:0]  last_step;
    } state_t;

endpackage

FILE: rtl/core/bemf_if.sv
// Valid/ready channel interfaces for items, results and configuration writes.
// Depends on bemf_pkg for the payload types.
interface bemf_item_if;
    logic            valid;
    logic            ready;
    bemf_pkg::item_t beat;

    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

interface bemf_result_if;
    logic              valid;
    logic              ready;
    bemf_pkg::result_t beat;

    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

interface bemf_cfg_if;
    logic                valid;
    logic                ready;
    bemf_pkg::cfg_beat_t beat;

    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

FILE: rtl/core/bemf_update.sv
// Single-pass state update for one item: tick counting, blanking, supply tracking, integration, detection.
// Depends on bemf_pkg.
module bemf_update
(
    input  bemf_pkg::cfg_t    cfg_q,
    input  bemf_pkg::state_t  state_q,
    input  bemf_pkg::item_t   item_q,
    output bemf_pkg::state_t  state_d,
    output bemf_pkg::result_t result_d
);

    logic [7:0]  blank_eff;
    logic [8:0]  half;
    logic        pol;
    logic        qualify;
    logic [9:0]  add;
    logic [16:0] sum;
    logic [15:0] acc;
    logic        fire;

    always_comb
    begin
        state_d   = state_q;
        fire      = 1'b0;
        half      = state_q.supply[9:1];
        blank_eff = (item_q.comm_step != state_q.last_step) ? cfg_q.blanking
                                                            : state_q.blank_left;
        pol       = ((item_q.comm_step < bemf_pkg::NUM_STEPS)
                     ? cfg_q.slope[item_q.comm_step] : 1'b0) ^ cfg_q.direction;
        if (pol)
        begin
            qualify = item_q.sample > {1'b0, half};
            add     = (item_q.sample < state_q.supply) ? (state_q.supply - item_q.sample)
                                                       : 10'd0;
        end
        else
        begin
            qualify = item_q.sample < {1'b0, half};
            add     = item_q.sample;
        end
        sum = {1'b0, state_q.integral} + {7'd0, add};
        acc = qualify ? (sum[16] ? bemf_pkg::U16_MAX : sum[15:0]) : 16'd0;

        if (item_q.req_type == bemf_pkg::REQ_TICK)
        begin
            if (state_q.tick_count != bemf_pkg::U16_MAX)
            begin
                state_d.tick_count = state_q.tick_count + 16'd1;
            end
        end
        else
        begin
            state_d.last_step = item_q.comm_step;
            if (blank_eff != 8'd0)
            begin
                state_d.blank_left = blank_eff - 8'd1;
            end
            else
            begin
                state_d.blank_left = blank_eff;
                if (item_q.sample_is_supply)
                begin
                    state_d.supply = item_q.sample;
                end
                else if (acc > cfg_q.threshold)
                begin
                    fire               = 1'b1;
                    state_d.integral   = 16'd0;
                    state_d.period     = state_q.tick_count;
                    state_d.tick_count = 16'd0;
                end
                else
                begin
                    state_d.integral = acc;
                end
            end
        end

        result_d.commutate      = fire;
        result_d.period         = state_d.period;
        result_d.integral_level = state_d.integral;
    end

endmodule

FILE: rtl/core/bemf_integration_commutation_detect_unit.sv
// Sensorless BLDC back-EMF integration and commutation detect, top level.
// Depends on bemf_pkg, bemf_if and bemf_update.
//
// Each item (timer tick or ADC sample) yields exactly one result beat. An item is taken
// into an input register, its whole update runs in combinational logic against the
// state registers, and the result lands in an output register; one item per cycle is
// sustained while results are taken. The output register frees its slot in the same
// cycle it is taken, so a stalled result holds the input register and, once that is
// full, the input as well: at most two beats are in flight. Configuration writes are
// always accepted and take effect from the next update out of the input register.
module bemf_integration_commutation_detect_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    bemf_item_if.sink            item,
    bemf_result_if.source        result,
    bemf_cfg_if.sink             cfg
);

    logic              in_valid_reg;
    bemf_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    bemf_pkg::result_t out_result_reg;
    bemf_pkg::cfg_t    cfg_reg;
    bemf_pkg::state_t  state_reg;
    bemf_pkg::state_t  state_next;
    bemf_pkg::result_t result_next;
    logic              advance;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready   = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.beat  = out_result_reg;

    bemf_update u_update
    (
        .cfg_q    (cfg_reg),
        .state_q  (state_reg),
        .item_q   (in_item_reg),
        .state_d  (state_next),
        .result_d (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_item_reg <= item.beat;
        end
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.tick_count <= 16'd0;
            state_reg.period     <= 16'd0;
            state_reg.integral   <= 16'd0;
            state_reg.supply     <= 10'd0;
            state_reg.blank_left <= bemf_pkg::RST_BLANK_LEFT;
            state_reg.last_step  <= 3'd0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= bemf_pkg::RST_THRESHOLD;
            cfg_reg.blanking  <= bemf_pkg::RST_BLANKING;
            cfg_reg.direction <= bemf_pkg::RST_DIRECTION;
            cfg_reg.slope     <= bemf_pkg::RST_SLOPE;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.beat.index)
                bemf_pkg::CFG_THRESHOLD: cfg_reg.threshold <= cfg.beat.data;
                bemf_pkg::CFG_BLANKING:  cfg_reg.blanking  <= cfg.beat.data[7:0];
                bemf_pkg::CFG_DIRECTION: cfg_reg.direction <= cfg.beat.data[0];
                bemf_pkg::CFG_SLOPE:     cfg_reg.slope     <= cfg.beat.data[5:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/core/bemf_checker.sv
// Port-level checker for the commutation detect unit, with its bind statement.
// Depends on bemf_pkg; attaches to bemf_integration_commutation_detect_unit.
module bemf_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input bemf_pkg::result_t out_beat
);

    logic        seen_reg;
    logic [15:0] period_reg;
    logic        out_fire;

    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= 1'b0;
            period_reg <= 16'd0;
        end
        else if (out_fire)
        begin
            seen_reg   <= 1'b1;
            period_reg <= out_beat.period;
        end
    end

    a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.commutate |-> out_beat.integral_level == 16'd0)
        else $error("commutate beat with nonzero integral");

    a_period_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && seen_reg && !out_beat.commutate |-> out_beat.period == period_reg)
        else $error("period changed without commutation");

    a_first_period: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !seen_reg && !out_beat.commutate |-> out_beat.period == 16'd0)
        else $error("period nonzero before first commutation");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_beat))
        else $error("result beat dropped or changed while stalled");

endmodule

bind bemf_integration_commutation_detect_unit bemf_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_beat  (result.beat)
);

FILE: bench/bemf_integration_commutation_detect_unit_test.sv
// Testbench for the back-EMF integration commutation detector: directed and random items,
// each result checked against a cycle-free predictor of the integrator state.
// Depends on bemf_pkg, bemf_if and the top level bemf_integration_commutation_detect_unit.
module bemf_integration_commutation_detect_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;

    bemf_item_if   item_bus();
    bemf_result_if result_bus();
    bemf_cfg_if    cfg_bus();

    bemf_integration_commutation_detect_unit uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic [15:0] cfg_threshold = bemf_pkg::RST_THRESHOLD;
    logic [7:0]  cfg_blanking  = bemf_pkg::RST_BLANKING;
    logic        cfg_direction = bemf_pkg::RST_DIRECTION;
    logic [5:0]  cfg_slope     = bemf_pkg::RST_SLOPE;

    logic [15:0] det_ticks      = '0;
    logic [15:0] det_period     = '0;
    logic [15:0] det_integral   = '0;
    logic [9:0]  det_supply     = '0;
    logic [7:0]  det_blank_left = bemf_pkg::RST_BLANK_LEFT;
    logic [2:0]  det_last_step  = '0;

    bemf_pkg::result_t pending_results[$];
    int      mismatches     = 0;
    int      items_sent     = 0;
    int      src_gap_pct    = 0;
    int      sink_stall_pct = 0;
    int      hold_req_seq   = 0;
    int      hold_req_len   = 0;

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[16] ? bemf_pkg::U16_MAX : sum[15:0];
    endfunction

    function automatic logic slope_falling(input logic [2:0] step);
        return ((step < bemf_pkg::NUM_STEPS) ? cfg_slope[step] : 1'b0) ^ cfg_direction;
    endfunction

    function automatic bemf_pkg::result_t next_detector_result(input bemf_pkg::item_t it);
        bemf_pkg::result_t res;
        logic [9:0] half;
        logic [9:0] falling_add;
        res.commutate = 1'b0;
        if (it.req_type == bemf_pkg::REQ_TICK)
        begin
            det_ticks = sat_add16(det_ticks, 16'd1);
        end
        else
        begin
            if (it.comm_step != det_last_step)
                det_blank_left = cfg_blanking;
            if (det_blank_left != 0)
                det_blank_left = det_blank_left - 8'd1;
            else if (it.sample_is_supply)
                det_supply = it.sample;
            else
            begin
                half = det_supply >> 1;
                if (slope_falling(it.comm_step))
                begin
                    falling_add = (it.sample < det_supply) ? det_supply - it.sample : '0;
                    det_integral = (it.sample > half) ?
                        sat_add16(det_integral, {6'd0, falling_add}) : '0;
                end
                else
                begin
                    det_integral = (it.sample < half) ?
                        sat_add16(det_integral, {6'd0, it.sample}) : '0;
                end
                if (det_integral > cfg_threshold)
                begin
                    res.commutate = 1'b1;
                    det_integral  = '0;
                    det_period    = det_ticks;
                    det_ticks     = '0;
                end
            end
            det_last_step = it.comm_step;
        end
        res.period         = det_period;
        res.integral_level = det_integral;
        return res;
    endfunction

    function automatic int idle_len();
        return ($urandom_range(7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic bemf_pkg::item_t sample_item(input logic [2:0] step,
                                                    input logic [9:0] value,
                                                    input logic supply_ch);
        return '{req_type: bemf_pkg::REQ_SAMPLE, sample: value, sample_is_supply: supply_ch,
                 comm_step: step};
    endfunction

    function automatic bemf_pkg::item_t tick_item();
        return '{req_type: bemf_pkg::REQ_TICK, sample: 10'($urandom_range(1023)),
                 sample_is_supply: 1'($urandom_range(1)), comm_step: 3'($urandom_range(7))};
    endfunction

    function automatic bemf_pkg::item_t random_item();
        bemf_pkg::item_t it;
        it = tick_item();
        it.req_type = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic logic [9:0] qualifying_sample(input logic [2:0] step);
        int half;
        int lo;
        half = det_supply >> 1;
        if (slope_falling(step))
        begin
            lo = half + 1;
            return 10'((int'(det_supply) - 1 >= lo) ?
                $urandom_range(lo, int'(det_supply) - 1) : $urandom_range(lo, 1023));
        end
        return 10'((half == 0) ? 0 : $urandom_range(0, half - 1));
    endfunction

    task automatic send_item(input bemf_pkg::item_t it);
        int gap;
        gap = ($urandom_range(99) < src_gap_pct) ? idle_len() : 0;
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.beat  <= it;
        @(posedge clk);
        while (!item_bus.ready) @(posedge clk);
        pending_results.push_back(next_detector_result(it));
        items_sent++;
    endtask

    task automatic drain_results();
        item_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input bemf_pkg::cfg_idx_t idx, input logic [15:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.beat  <= '{index: idx, data: value};
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        case (idx)
            bemf_pkg::CFG_THRESHOLD: cfg_threshold = value;
            bemf_pkg::CFG_BLANKING:  cfg_blanking  = value[7:0];
            bemf_pkg::CFG_DIRECTION: cfg_direction = value[0];
            bemf_pkg::CFG_SLOPE:     cfg_slope     = value[5:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] threshold, input logic [7:0] blanking,
                             input logic direction, input logic [5:0] slope);
        write_reg(bemf_pkg::CFG_THRESHOLD, threshold);
        write_reg(bemf_pkg::CFG_BLANKING, {8'd0, blanking});
        write_reg(bemf_pkg::CFG_DIRECTION, {15'd0, direction});
        write_reg(bemf_pkg::CFG_SLOPE, {10'd0, slope});
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic run_step_sequence(input logic [2:0] step, input int len);
        int roll;
        if (step != det_last_step && cfg_blanking <= 8)
            repeat (cfg_blanking)
                send_item(sample_item(step, 10'($urandom_range(1023)), 1'($urandom_range(1))));
        send_item(sample_item(step, 10'(($urandom_range(3) == 0) ?
            $urandom_range(1023) : $urandom_range(700, 1023)), 1'b1));
        repeat (len)
        begin
            roll = $urandom_range(99);
            if (roll < 10)
                send_item(tick_item());
            else if (roll < 18)
                send_item(sample_item(step, 10'($urandom_range(1023)), 1'($urandom_range(1))));
            else
                send_item(sample_item(step, qualifying_sample(step), 1'b0));
        end
    endtask

    task automatic test_reset_defaults();
        src_gap_pct    = 20;
        sink_stall_pct = 20;
        send_item('{req_type: bemf_pkg::REQ_TICK, sample: 10'h3FF, sample_is_supply: 1'b1,
                    comm_step: 3'd7});
        send_item(sample_item(3'd0, 10'h3FF, 1'b1));
        send_item(sample_item(3'd0, 10'h3FF, 1'b1));
        send_item(sample_item(3'd0, 10'd1000, 1'b1));
        repeat (3) send_item(sample_item(3'd0, 10'd600, 1'b0));
        repeat (2) send_item(tick_item());
        repeat (3) send_item(sample_item(3'd1, 10'd100, 1'b0));
        send_item(sample_item(3'd1, 10'd700, 1'b0));
        send_item(sample_item(3'd1, 10'd100, 1'b0));
        send_item(sample_item(3'd1, 10'd500, 1'b0));
        drain_results();
    endtask

    task automatic test_field_extremes();
        configure(16'd0, 8'd0, 1'b1, 6'h3F);
        send_item(sample_item(3'd2, 10'h3FF, 1'b1));
        send_item(sample_item(3'd2, 10'd0, 1'b0));
        send_item(sample_item(3'd2, 10'd1, 1'b0));
        send_item(sample_item(3'd6, 10'h3FF, 1'b0));
        send_item(sample_item(3'd7, 10'd600, 1'b0));
        send_item(sample_item(3'd7, 10'd512, 1'b0));
        send_item(sample_item(3'd7, 10'd511, 1'b0));
        send_item(sample_item(3'd7, 10'd0, 1'b1));
        send_item(sample_item(3'd7, 10'd0, 1'b0));
        send_item(tick_item());
        drain_results();
        configure(bemf_pkg::U16_MAX, 8'd0, 1'b0, 6'd0);
        send_item(sample_item(3'd0, 10'h3FF, 1'b1));
        repeat (3) send_item(sample_item(3'd0, 10'd510, 1'b0));
        drain_results();
    endtask

    task automatic test_saturation();
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        repeat (140) send_item(sample_item(3'd0, 10'd510, 1'b0));
        repeat (20) send_item(tick_item());
        drain_results();
        configure(16'd0, 8'd0, 1'b0, 6'd0);
        send_item(sample_item(3'd0, 10'd5, 1'b0));
        drain_results();
    endtask

    task automatic test_backpressure();
        configure(16'd600, 8'd1, 1'b0, bemf_pkg::RST_SLOPE);
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        hold_req_len   = 80;
        hold_req_seq++;
        run_step_sequence(3'd0, 12);
        run_step_sequence(3'd1, 12);
        drain_results();
    endtask

    task automatic test_random_phases();
        int start;
        int quota;
        for (int ph = 0; ph < 7; ph++)
        begin
            drain_results();
            case (ph)
                0: configure(16'd0, 8'd0, 1'b0, 6'd0);
                1: configure(bemf_pkg::U16_MAX, 8'hFF, 1'b1, 6'h3F);
                default: configure(16'($urandom_range(100, 3000)), 8'($urandom_range(3)),
                                   1'($urandom_range(1)), 6'($urandom_range(63)));
            endcase
            src_gap_pct    = (ph % 3 == 0) ? 0 : $urandom_range(10, 40);
            sink_stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 40);
            quota = (ph == 1) ? 40 : 70;
            start = items_sent;
            while (items_sent - start < quota)
            begin
                if ($urandom_range(4) == 0)
                    send_item(random_item());
                else
                    run_step_sequence(3'(($urandom_range(9) == 0) ?
                        $urandom_range(6, 7) : $urandom_range(5)), $urandom_range(3, 20));
            end
        end
        drain_results();
    endtask

    task automatic check_result(input bemf_pkg::result_t got);
        bemf_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result beat: commutate %0d period %0d integral_level %0d",
                   got.commutate, got.period, got.integral_level);
            mismatches++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.commutate !== want.commutate)
            begin
                $error("commutate: expected %0d, got %0d", want.commutate, got.commutate);
                mismatches++;
            end
            if (got.period !== want.period)
            begin
                $error("period: expected %0d, got %0d", want.period, got.period);
                mismatches++;
            end
            if (got.integral_level !== want.integral_level)
            begin
                $error("integral_level: expected %0d, got %0d",
                       want.integral_level, got.integral_level);
                mismatches++;
            end
        end
    endtask

    initial
    begin : result_sink
        int hold_seen;
        int hold_left;
        int stall_left;
        hold_seen  = 0;
        hold_left  = 0;
        stall_left = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready)
                check_result(result_bus.beat);
            if (hold_req_seq != hold_seen)
            begin
                hold_seen = hold_req_seq;
                hold_left = hold_req_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else if ($urandom_range(99) < sink_stall_pct)
            begin
                stall_left = idle_len() - 1;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n            <= 1'b0;
        item_bus.valid   <= 1'b0;
        item_bus.beat    <= '0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.beat     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_field_extremes();
        test_saturation();
        test_backpressure();
        test_random_phases();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
